[rtl/upd_pkg.sv]
// Package with byte codes, the queued result type and the decode helper functions.
package upd_pkg;

    // Character codes seen in form-encoded strings.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // One decoded output item.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } upd_item_t;

    // Hex digit lookup: bit 4 flags a valid digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = 8'h00;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                diff = c - CH_ZERO;
                hex_nibble = {1'b1, diff[3:0]};
            end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
                diff = c - CH_LOWER_A + 8'd10;
                hex_nibble = {1'b1, diff[3:0]};
            end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
                diff = c - CH_UPPER_A + 8'd10;
                hex_nibble = {1'b1, diff[3:0]};
            end else begin
                hex_nibble = 5'b0_0000;
            end
        end
    endfunction

    // Whitespace as a number parser skips it: space, tab, LF, VT, FF, CR.
    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // A plus sign stands for a space; everything else passes.
    function automatic logic [7:0] plain_byte(input logic [7:0] c);
        plain_byte = (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    // Value of a two-byte escape, parsed as a base-16 number with an optional leading blank, plus or minus sign.
    function automatic logic [7:0] escape_value(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        begin
            ha = hex_nibble(a);
            hb = hex_nibble(b);
            if (ha[4]) begin
                escape_value = hb[4] ? {ha[3:0], hb[3:0]} : {4'h0, ha[3:0]};
            end else if (is_blank(a) || a == CH_PLUS) begin
                escape_value = hb[4] ? {4'h0, hb[3:0]} : 8'h00;
            end else if (a == CH_MINUS) begin
                escape_value = hb[4] ? (8'h00 - {4'h0, hb[3:0]}) : 8'h00;
            end else begin
                escape_value = 8'h00;
            end
        end
    endfunction

endpackage

[rtl/url_percent_decoder_unit.sv]
// Streaming URL form decoder: one encoded byte in, zero to two decoded bytes out.
// Decoded bytes are registered in the output queue before they appear on the master side.
// Throughput: one input item per cycle; a three-entry output queue absorbs the
// two-result items at string end, and the input stalls only while two or more results wait.
// Reset (aresetn low, synchronous) clears the escape state and empties the queue.
module url_percent_decoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte [7:0]
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte [7:0]
    output logic       m_tlast    // out_last
);
    import upd_pkg::*;

    // Escape phases.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_PCT    = 2'd1;
    localparam logic [1:0] PH_DIGIT  = 2'd2;

    localparam int QDEPTH = 3;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] first_reg, first_next;
    upd_item_t  q_reg [QDEPTH];
    upd_item_t  q_next [QDEPTH];
    logic [1:0] cnt_reg, cnt_next;

    logic       s_acc;
    logic       m_acc;
    logic [1:0] push_n;
    upd_item_t  res0;
    upd_item_t  res1;
    logic [1:0] base;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= 2'd1);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q_reg[0].data;
    assign m_tlast  = q_reg[0].last;

    // Decode of the accepted byte against the escape state.
    always_comb begin
        phase_next = phase_reg;
        first_next = first_reg;
        push_n     = 2'd0;
        res0       = '{data: plain_byte(s_tdata), last: s_tlast};
        res1       = '{data: plain_byte(s_tdata), last: 1'b1};
        if (s_acc) begin
            case (phase_reg)
                PH_PCT: begin
                    if (s_tlast) begin
                        // Percent sign was second to last: emit it literally first.
                        res0       = '{data: CH_PERCENT, last: 1'b0};
                        push_n     = 2'd2;
                        phase_next = PH_IDLE;
                        first_next = 8'h00;
                    end else begin
                        first_next = s_tdata;
                        phase_next = PH_DIGIT;
                    end
                end
                PH_DIGIT: begin
                    res0       = '{data: escape_value(first_reg, s_tdata), last: s_tlast};
                    push_n     = 2'd1;
                    phase_next = PH_IDLE;
                    first_next = 8'h00;
                end
                default: begin
                    phase_next = PH_IDLE;
                    if (s_tdata == CH_PERCENT && !s_tlast) begin
                        phase_next = PH_PCT;
                    end else begin
                        push_n = 2'd1;
                    end
                end
            endcase
        end
    end

    // Output queue: the head sits in entry 0, a pop shifts the rest down.
    always_comb begin
        q_next = q_reg;
        if (m_acc) begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
        base = cnt_reg - {1'b0, m_acc};
        if (push_n != 2'd0) begin
            q_next[base] = res0;
        end
        if (push_n == 2'd2) begin
            q_next[base + 2'd1] = res1;
        end
        cnt_next = base + push_n;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            first_reg <= 8'h00;
            cnt_reg   <= 2'd0;
        end else begin
            phase_reg <= phase_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    // A string end always returns the escape logic to idle.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (phase_reg == PH_IDLE))
        else $error("escape state not cleared at string end");

    // A plain byte in idle phase always leaves something to deliver.
    a_plain_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && phase_reg == PH_IDLE && s_tdata != CH_PERCENT) |=> m_tvalid)
        else $error("plain byte produced no output item");

    // A stalled head item is never dropped from the queue.
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && cnt_reg >= $past(cnt_reg)))
        else $error("queued item lost while stalled");

endmodule
